FILE: rtl/core/c6502_dec_pkg.sv
package c6502_dec_pkg;

  // Addressing modes as reported on access_mode
  localparam logic [3:0] M_NONE = 4'd0;
  localparam logic [3:0] M_IMPL = 4'd1;
  localparam logic [3:0] M_ACC  = 4'd2;
  localparam logic [3:0] M_IMM  = 4'd3;
  localparam logic [3:0] M_ZPG  = 4'd4;
  localparam logic [3:0] M_ZPGX = 4'd5;
  localparam logic [3:0] M_ZPGY = 4'd6;
  localparam logic [3:0] M_ABS  = 4'd7;
  localparam logic [3:0] M_ABSX = 4'd8;
  localparam logic [3:0] M_ABSY = 4'd9;
  localparam logic [3:0] M_IND  = 4'd10;
  localparam logic [3:0] M_INDX = 4'd11;
  localparam logic [3:0] M_INDY = 4'd12;
  localparam logic [3:0] M_REL  = 4'd13;

  // Mnemonics, alphabetical from 1
  localparam logic [5:0] O_NONE = 6'd0;
  localparam logic [5:0] O_ADC = 6'd1;
  localparam logic [5:0] O_AND = 6'd2;
  localparam logic [5:0] O_ASL = 6'd3;
  localparam logic [5:0] O_BCC = 6'd4;
  localparam logic [5:0] O_BCS = 6'd5;
  localparam logic [5:0] O_BEQ = 6'd6;
  localparam logic [5:0] O_BIT = 6'd7;
  localparam logic [5:0] O_BMI = 6'd8;
  localparam logic [5:0] O_BNE = 6'd9;
  localparam logic [5:0] O_BPL = 6'd10;
  localparam logic [5:0] O_BRK = 6'd11;
  localparam logic [5:0] O_BVC = 6'd12;
  localparam logic [5:0] O_BVS = 6'd13;
  localparam logic [5:0] O_CLC = 6'd14;
  localparam logic [5:0] O_CLD = 6'd15;
  localparam logic [5:0] O_CLI = 6'd16;
  localparam logic [5:0] O_CLV = 6'd17;
  localparam logic [5:0] O_CMP = 6'd18;
  localparam logic [5:0] O_CPX = 6'd19;
  localparam logic [5:0] O_CPY = 6'd20;
  localparam logic [5:0] O_DEC = 6'd21;
  localparam logic [5:0] O_DEX = 6'd22;
  localparam logic [5:0] O_DEY = 6'd23;
  localparam logic [5:0] O_EOR = 6'd24;
  localparam logic [5:0] O_INC = 6'd25;
  localparam logic [5:0] O_INX = 6'd26;
  localparam logic [5:0] O_INY = 6'd27;
  localparam logic [5:0] O_JMP = 6'd28;
  localparam logic [5:0] O_JSR = 6'd29;
  localparam logic [5:0] O_LDA = 6'd30;
  localparam logic [5:0] O_LDX = 6'd31;
  localparam logic [5:0] O_LDY = 6'd32;
  localparam logic [5:0] O_LSR = 6'd33;
  localparam logic [5:0] O_NOP = 6'd34;
  localparam logic [5:0] O_ORA = 6'd35;
  localparam logic [5:0] O_PHA = 6'd36;
  localparam logic [5:0] O_PHP = 6'd37;
  localparam logic [5:0] O_PLA = 6'd38;
  localparam logic [5:0] O_PLP = 6'd39;
  localparam logic [5:0] O_ROL = 6'd40;
  localparam logic [5:0] O_ROR = 6'd41;
  localparam logic [5:0] O_RTI = 6'd42;
  localparam logic [5:0] O_RTS = 6'd43;
  localparam logic [5:0] O_SBC = 6'd44;
  localparam logic [5:0] O_SEC = 6'd45;
  localparam logic [5:0] O_SED = 6'd46;
  localparam logic [5:0] O_SEI = 6'd47;
  localparam logic [5:0] O_STA = 6'd48;
  localparam logic [5:0] O_STX = 6'd49;
  localparam logic [5:0] O_STY = 6'd50;
  localparam logic [5:0] O_TAX = 6'd51;
  localparam logic [5:0] O_TAY = 6'd52;
  localparam logic [5:0] O_TSX = 6'd53;
  localparam logic [5:0] O_TXA = 6'd54;
  localparam logic [5:0] O_TXS = 6'd55;
  localparam logic [5:0] O_TYA = 6'd56;

  // Opcode group (bits 1..0)
  localparam logic [1:0] GRP_CTL = 2'd0;
  localparam logic [1:0] GRP_ALU = 2'd1;
  localparam logic [1:0] GRP_RMW = 2'd2;

  // Group 1 tables, indexed by operation field / mode field
  localparam logic [5:0] ALU_OPS [8] = '{O_ORA, O_AND, O_EOR, O_ADC,
                                         O_STA, O_LDA, O_CMP, O_SBC};
  localparam logic [3:0] ALU_MODES [8] = '{M_INDX, M_ZPG, M_IMM, M_ABS,
                                           M_INDY, M_ZPGX, M_ABSY, M_ABSX};
  // Group 2 tables
  localparam logic [5:0] RMW_OPS [8] = '{O_ASL, O_ROL, O_LSR, O_ROR,
                                         O_STX, O_LDX, O_DEC, O_INC};
  localparam logic [3:0] RMW_MODES [8] = '{M_IMM, M_ZPG, M_ACC, M_ABS,
                                           M_NONE, M_ZPGX, M_NONE, M_ABSX};
  localparam logic [5:0] ACC_ALT [4] = '{O_TXA, O_TAX, O_DEX, O_NOP};
  // Group 0 tables
  localparam logic [5:0] BR_OPS [8] = '{O_BPL, O_BMI, O_BVC, O_BVS,
                                        O_BCC, O_BCS, O_BNE, O_BEQ};
  localparam logic [5:0] IMP_LO [8] = '{O_PHP, O_PLP, O_PHA, O_PLA,
                                        O_DEY, O_TAY, O_INY, O_INX};
  localparam logic [5:0] IMP_HI [8] = '{O_CLC, O_SEC, O_CLI, O_SEI,
                                        O_TYA, O_CLV, O_CLD, O_SED};
  localparam logic [5:0] SYS_OPS [4] = '{O_BRK, O_JSR, O_RTI, O_RTS};
  localparam logic [5:0] CTL_OPS [8] = '{O_NONE, O_BIT, O_JMP, O_JMP,
                                         O_STY, O_LDY, O_CPY, O_CPX};
  localparam logic [3:0] CTL_MODES [8] = '{M_IMM, M_ZPG, M_NONE, M_ABS,
                                           M_NONE, M_ZPGX, M_NONE, M_ABSX};
  // Per mode field: which operation fields are documented
  localparam logic [7:0] CTL_OK [8] = '{8'hE0, 8'hF2, 8'h00, 8'hFE,
                                        8'h00, 8'h30, 8'h00, 8'h20};

  typedef struct packed {
    logic [5:0] operation;
    logic [3:0] access_mode;
    logic       is_illegal;
  } dec_res_t;

endpackage

FILE: rtl/core/c6502_dec_logic.sv
module c6502_dec_logic
  import c6502_dec_pkg::*;
(
  input  logic [7:0] instr_byte,
  output dec_res_t   res
);

  // Mode field values with special meaning
  localparam logic [2:0] MM_SYS     = 3'd0;
  localparam logic [2:0] MM_IMPL_LO = 3'd2;
  localparam logic [2:0] MM_BRANCH  = 3'd4;
  localparam logic [2:0] MM_IMPL_HI = 3'd6;
  localparam logic [2:0] MM_LAST    = 3'd7;
  // Operation field values with special meaning
  localparam logic [2:0] HI_JSR  = 3'd1;
  localparam logic [2:0] HI_JMPI = 3'd3;
  localparam logic [2:0] HI_STX  = 3'd4;
  localparam logic [2:0] HI_LDX  = 3'd5;

  logic [1:0] cc;
  logic [2:0] mm;
  logic [2:0] hi;
  logic [5:0] op;
  logic [3:0] md;
  logic       bad;

  assign cc = instr_byte[1:0];
  assign mm = instr_byte[4:2];
  assign hi = instr_byte[7:5];

  always_comb begin
    op  = O_NONE;
    md  = M_NONE;
    bad = 1'b0;
    case (cc)
      GRP_CTL: begin
        if (mm == MM_BRANCH) begin
          op = BR_OPS[hi];
          md = M_REL;
        end else if (mm == MM_IMPL_LO) begin
          op = IMP_LO[hi];
          md = M_IMPL;
        end else if (mm == MM_IMPL_HI) begin
          op = IMP_HI[hi];
          md = M_IMPL;
        end else if (mm == MM_SYS && !hi[2]) begin
          op = SYS_OPS[hi[1:0]];
          md = (hi == HI_JSR) ? M_ABS : M_IMPL;
        end else begin
          op  = CTL_OPS[hi];
          md  = CTL_MODES[mm];
          bad = !CTL_OK[mm][hi];
          if (hi == HI_JMPI) md = M_IND;
        end
      end
      GRP_ALU: begin
        op  = ALU_OPS[hi];
        md  = ALU_MODES[mm];
        bad = (hi == HI_STX) && (mm == MM_IMPL_LO);
      end
      GRP_RMW: begin
        if (mm == MM_IMPL_HI) begin
          if (hi == HI_STX) begin
            op = O_TXS;
            md = M_IMPL;
          end else if (hi == HI_LDX) begin
            op = O_TSX;
            md = M_IMPL;
          end else begin
            bad = 1'b1;
          end
        end else if (mm == MM_BRANCH) begin
          bad = 1'b1;
        end else begin
          op = RMW_OPS[hi];
          md = RMW_MODES[mm];
          // LDX/STX index with Y instead of X
          if (hi == HI_STX || hi == HI_LDX) begin
            if (md == M_ZPGX) md = M_ZPGY;
            else if (md == M_ABSX) md = M_ABSY;
          end
          if (mm == MM_SYS) begin
            bad = (hi != HI_LDX);
          end else if (mm == MM_IMPL_LO && hi[2]) begin
            op = ACC_ALT[hi[1:0]];
            md = M_IMPL;
          end else if (mm == MM_LAST && hi == HI_STX) begin
            bad = 1'b1;
          end
        end
      end
      default: bad = 1'b1;
    endcase
    if (op == O_NONE || md == M_NONE) bad = 1'b1;
    res.operation   = bad ? O_NONE : op;
    res.access_mode = bad ? M_NONE : md;
    res.is_illegal  = bad;
  end

endmodule

FILE: rtl/core/cpu6502_opcode_decoder.sv
// NMOS 6502 opcode decoder. Each request carries one opcode byte and yields
// one result: the documented mnemonic (1..56, alphabetical), its addressing
// mode and an illegal flag; undocumented bytes give operation 0, mode 0 and
// is_illegal 1. A request is taken every cycle when the output is not
// stalled; after acceptance the opcode passes through the input register,
// the single decode stage and the result register, and the result is
// presented from the result register.
module cpu6502_opcode_decoder
  import c6502_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] instr_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] operation,
  output logic [3:0] access_mode,
  output logic       is_illegal
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       res_valid;
  dec_res_t   res;
  dec_res_t   res_next;
  logic       res_advance;

  c6502_dec_logic u_logic (
    .instr_byte (stage_byte),
    .res        (res_next)
  );

  assign res_advance = !res_valid || out_ready;
  assign in_ready    = !stage_valid || res_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= instr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_advance) begin
      res_valid <= stage_valid;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (res_advance && stage_valid) begin
      res <= res_next;
    end
  end

  assign out_valid   = res_valid;
  assign operation   = res.operation;
  assign access_mode = res.access_mode;
  assign is_illegal  = res.is_illegal;

endmodule
